// File: sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define NLT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("liveness tracker assertion failed");

// consequence checked in the cycle after the antecedent
`define NLT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("liveness tracker assertion failed");

`endif

// File: sv/nlt_pkg.sv
// types, codes and a helper function for the node liveness tracker
// no dependencies
`default_nettype none
package nlt_pkg;

  localparam int NODE_W      = 4;
  localparam int MAX_NODES   = 1 << NODE_W;
  localparam int RUN_W       = 16;
  localparam int TOTAL_W     = 32;
  localparam int TIME_W      = 32;
  localparam int RETRY_W     = 16;
  localparam int THR_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = THR_W;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_REPLIES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSES_TO_MISSING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSES_TO_OFFLINE = 2'd2;

  // event kinds
  localparam logic FUNC_REPLY = 1'b0;
  localparam logic FUNC_MISS  = 1'b1;

  typedef enum logic [2:0] {
    ST_UNSEEN     = 3'd0,
    ST_DISCOVERED = 3'd1,
    ST_ONLINE     = 3'd2,
    ST_MISSING    = 3'd3,
    ST_OFFLINE    = 3'd4
  } node_st_t;

  typedef struct packed {
    logic               func;
    logic [NODE_W-1:0]  node;
    logic [TIME_W-1:0]  now_ms;
    logic [RETRY_W-1:0] init_retries;
  } nlt_in_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node_out;
    node_st_t           state_now;
    node_st_t           state_before;
    logic               changed;
    logic [RUN_W-1:0]   reply_run;
    logic [RUN_W-1:0]   miss_run;
    logic [TOTAL_W-1:0] reply_total;
    logic [TIME_W-1:0]  first_reply_ms;
    logic [RETRY_W-1:0] first_seen_retries;
  } nlt_out_t;

  typedef struct packed {
    logic [THR_W-1:0] stable_replies;
    logic [THR_W-1:0] misses_to_missing;
    logic [THR_W-1:0] misses_to_offline;
  } nlt_thr_t;

  typedef struct packed {
    node_st_t           state;
    logic [RUN_W-1:0]   reply_run;
    logic [RUN_W-1:0]   miss_run;
    logic [TOTAL_W-1:0] reply_total;
    logic [TIME_W-1:0]  first_ms;
    logic [RETRY_W-1:0] first_retries;
  } nlt_entry_t;

  function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] v);
    return (v == RUN_MAX) ? RUN_MAX : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// File: sv/nlt_cfg_regs.sv
// threshold registers written through the configuration port
// depends on nlt_pkg
`default_nettype none
module nlt_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [nlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nlt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output nlt_pkg::nlt_thr_t                    thr
);
  import nlt_pkg::*;

  nlt_thr_t thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.stable_replies    <= 8'd3;
      thr_r.misses_to_missing <= 8'd3;
      thr_r.misses_to_offline <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STABLE_REPLIES:    thr_r.stable_replies    <= cfg_wdata;
        CFG_MISSES_TO_MISSING: thr_r.misses_to_missing <= cfg_wdata;
        CFG_MISSES_TO_OFFLINE: thr_r.misses_to_offline <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign thr = thr_r;

endmodule
`default_nettype wire

// File: sv/nlt_node_table.sv
// per-node record table in flip-flops, one read and one write port
// depends on nlt_pkg
`default_nettype none
module nlt_node_table #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [IDX_W-1:0]     rd_idx,
  output nlt_pkg::nlt_entry_t       rd_entry,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_idx,
  input  wire nlt_pkg::nlt_entry_t  wr_entry
);
  import nlt_pkg::*;

  node_st_t           state_r       [ENTRIES];
  logic [RUN_W-1:0]   reply_run_r   [ENTRIES];
  logic [RUN_W-1:0]   miss_run_r    [ENTRIES];
  logic [TOTAL_W-1:0] reply_total_r [ENTRIES];
  logic [TIME_W-1:0]  first_ms_r    [ENTRIES];
  logic [RETRY_W-1:0] first_retr_r  [ENTRIES];

  // counters and state cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        state_r[i]       <= ST_UNSEEN;
        reply_run_r[i]   <= '0;
        miss_run_r[i]    <= '0;
        reply_total_r[i] <= '0;
      end
    end else if (wr_en) begin
      state_r[wr_idx]       <= wr_entry.state;
      reply_run_r[wr_idx]   <= wr_entry.reply_run;
      miss_run_r[wr_idx]    <= wr_entry.miss_run;
      reply_total_r[wr_idx] <= wr_entry.reply_total;
    end
  end

  // first-reply record, only read once the node has left unseen
  always_ff @(posedge clk) begin
    if (wr_en) begin
      first_ms_r[wr_idx]   <= wr_entry.first_ms;
      first_retr_r[wr_idx] <= wr_entry.first_retries;
    end
  end

  always_comb begin
    rd_entry.state         = state_r[rd_idx];
    rd_entry.reply_run     = reply_run_r[rd_idx];
    rd_entry.miss_run      = miss_run_r[rd_idx];
    rd_entry.reply_total   = reply_total_r[rd_idx];
    rd_entry.first_ms      = first_ms_r[rd_idx];
    rd_entry.first_retries = first_retr_r[rd_idx];
  end

endmodule
`default_nettype wire

// File: sv/nlt_update.sv
// next record and transaction result for one event
// depends on nlt_pkg
`default_nettype none
module nlt_update (
  input  wire nlt_pkg::nlt_in_t     item,
  input  wire logic                 in_range,
  input  wire nlt_pkg::nlt_entry_t  cur,
  input  wire nlt_pkg::nlt_thr_t    thr,
  output nlt_pkg::nlt_entry_t       nxt,
  output nlt_pkg::nlt_out_t         res
);
  import nlt_pkg::*;

  node_st_t st;

  always_comb begin
    nxt = cur;
    st  = cur.state;
    if (item.func == FUNC_REPLY) begin
      nxt.reply_total = cur.reply_total + 1'b1;
      nxt.reply_run   = run_inc(cur.reply_run);
      nxt.miss_run    = '0;
      case (cur.state) inside
        ST_UNSEEN: begin
          st                = ST_DISCOVERED;
          nxt.first_ms      = item.now_ms;
          nxt.first_retries = item.init_retries;
        end
        ST_OFFLINE: begin
          st            = ST_DISCOVERED;
          nxt.reply_run = {{(RUN_W-1){1'b0}}, 1'b1};
        end
        ST_DISCOVERED, ST_MISSING: begin
          if (nxt.reply_run >= {{(RUN_W-THR_W){1'b0}}, thr.stable_replies})
            st = ST_ONLINE;
        end
        default: ;
      endcase
    end else if (cur.state != ST_UNSEEN) begin
      nxt.miss_run  = run_inc(cur.miss_run);
      nxt.reply_run = '0;
      case (cur.state) inside
        ST_ONLINE: begin
          if (nxt.miss_run >= {{(RUN_W-THR_W){1'b0}}, thr.misses_to_missing})
            st = ST_MISSING;
        end
        ST_DISCOVERED, ST_MISSING: begin
          if (nxt.miss_run >= {{(RUN_W-THR_W){1'b0}}, thr.misses_to_offline})
            st = ST_OFFLINE;
        end
        default: ;
      endcase
    end
    nxt.state = st;
  end

  always_comb begin
    res          = '0;
    res.node_out = item.node;
    if (in_range) begin
      res.state_now    = st;
      res.state_before = cur.state;
      res.changed      = (st != cur.state);
      res.reply_run    = nxt.reply_run;
      res.miss_run     = nxt.miss_run;
      res.reply_total  = nxt.reply_total;
      if (st != ST_UNSEEN) begin
        res.first_reply_ms     = nxt.first_ms;
        res.first_seen_retries = nxt.first_retries;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/node_liveness_tracker.sv
// node liveness tracker top level: input register, record update, result register
// depends on nlt_pkg, nlt_cfg_regs, nlt_node_table, nlt_update
//
//   port group  direction  handshake            payload
//   in_         input      in_valid / in_ready  in_data   (nlt_in_t)
//   out_        output     out_valid/out_ready  out_data  (nlt_out_t)
//   cfg_        input      cfg_we               cfg_index, cfg_wdata
//
// one transaction per cycle unless out_ready stalls; result via input then result register
// the record read-modify-write of the node table sits between the input and result registers
// an event for the same node may follow in the next cycle and sees the updated record
// synchronous reset clears node states and counters and loads default thresholds
// a stalled result holds the input register; in_ready stays high while the result moves
`default_nettype none
module node_liveness_tracker #(
  parameter int NODES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_ready,
  input  wire nlt_pkg::nlt_in_t                in_data,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output nlt_pkg::nlt_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [nlt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nlt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import nlt_pkg::*;

  localparam int ENTRIES = (NODES < MAX_NODES) ? NODES : MAX_NODES;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic       s1_valid_r;
  nlt_in_t    s1_r;
  logic       out_valid_r;
  nlt_out_t   out_data_r;
  logic       advance;
  logic       in_range;
  logic [IDX_W-1:0] idx;
  nlt_thr_t   thr;
  nlt_entry_t cur_entry;
  nlt_entry_t nxt_entry;
  nlt_out_t   result;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_range = ({1'b0, s1_r.node} < (NODE_W+1)'(ENTRIES));
  assign idx      = s1_r.node[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  nlt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  nlt_node_table #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx),
    .rd_entry (cur_entry),
    .wr_en    (advance && in_range),
    .wr_idx   (idx),
    .wr_entry (nxt_entry)
  );

  nlt_update u_update (
    .item     (s1_r),
    .in_range (in_range),
    .cur      (cur_entry),
    .thr      (thr),
    .nxt      (nxt_entry),
    .res      (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: sv/nlt_checker.sv
// port-level checks for the node liveness tracker, bound to the top level
// depends on nlt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module nlt_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire nlt_pkg::nlt_out_t out_data
);
  import nlt_pkg::*;

  logic st_differs;
  logic unseen_out;
  logic unseen_clear;
  logic online_entry;
  logic online_src_ok;

  assign st_differs    = (out_data.state_now != out_data.state_before);
  assign unseen_out    = out_valid && (out_data.state_now == ST_UNSEEN);
  assign unseen_clear  = (out_data.reply_total == '0) && (out_data.first_reply_ms == '0) &&
                         (out_data.first_seen_retries == '0);
  assign online_entry  = out_valid && out_data.changed && (out_data.state_now == ST_ONLINE);
  assign online_src_ok = (out_data.state_before == ST_DISCOVERED) ||
                         (out_data.state_before == ST_MISSING);

  `NLT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `NLT_ASSERT_IMP(a_changed, clk, rst_n, out_valid, out_data.changed == st_differs)
  `NLT_ASSERT_IMP(a_unseen_empty, clk, rst_n, unseen_out, unseen_clear)
  `NLT_ASSERT_IMP(a_online_src, clk, rst_n, online_entry, online_src_ok)

endmodule

bind node_liveness_tracker nlt_checker u_nlt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
